### rtl/fdlm_pkg.sv
// Types, codes and constants shared by the fault debounce latch manager.
package fdlm_pkg;

   localparam int FAULT_SLOTS = 16;
   localparam int SLOT_W      = $clog2(FAULT_SLOTS);
   localparam int COUNT_W     = $clog2(FAULT_SLOTS + 1);
   localparam int TIME_W      = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(FAULT_SLOTS);

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_WRITE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_STATE    = 2'd1,
      ST_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      LATCH_NONE   = 2'd0,
      LATCH_MANUAL = 2'd1,
      LATCH_POWER  = 2'd2
   } latch_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [SLOT_W-1:0] fault_id;
      logic              fault_raw;
      logic [TIME_W-1:0] delta_ms;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] trip_limit_ms;
      logic [TIME_W-1:0] recovery_limit_ms;
      logic [1:0]        latch_mode;
      logic [31:0]       slot_actions;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] trip_timer;
      logic [TIME_W-1:0] recovery_timer;
      logic              raw_flag;
      logic              active_flag;
      logic              latched_flag;
      logic              history_flag;
      logic [31:0]       occurrences;
      logic [TIME_W-1:0] first_seen;
      logic [TIME_W-1:0] change_time;
   } slot_type;

   typedef struct packed {
      logic [TIME_W-1:0] trip_limit;
      logic [TIME_W-1:0] recovery_limit;
      logic [1:0]        latch_mode;
      logic [31:0]       actions;
   } desc_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              is_active;
      logic              is_latched;
      logic              is_effective;
      logic              raw_seen;
      logic [31:0]       occurrences;
      logic [TIME_W-1:0] first_stamp;
      logic [TIME_W-1:0] change_stamp;
      logic              ever_active;
      logic [31:0]       combined_actions;
   } rsp_type;

endpackage

### rtl/fault_debounce_latch_manager_top.sv
// Fault debounce latch manager: slot table, debounce update and result register.
//
// Usage:
//   req_* carries one item per accepted handshake (req_valid high, req_stall
//   low): a raw fault update, a manual latch clear request or a slot
//   descriptor write. rsp_* returns exactly one result item per request, in
//   order, taken when rsp_valid is high and rsp_stall is low.
//   csr_* writes the number of slots in use; csr_ready is always high and the
//   write should only be issued while no item is in flight.
//   Flow: an accepted item is held in the input register, and its result is
//   loaded into the result register when that register is empty or its
//   item is being taken, and rsp_valid then rises. Throughput: one item per
//   cycle while rsp_stall is low; the slot state is read, updated and
//   written back combinationally between the two registers, so back-to-back
//   items on one slot see each other.
//   When rsp_stall is held, the result register holds its item, the input
//   register fills with the next item and then req_stall rises.
//   Reset clears all slot state and descriptors, sets the slot count to 16
//   and empties both registers.
module fault_debounce_latch_manager_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic [fdlm_pkg::SLOT_W-1:0]     req_fault_id,
   input  logic                            req_fault_raw,
   input  logic [fdlm_pkg::TIME_W-1:0]     req_delta_ms,
   input  logic [fdlm_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [fdlm_pkg::TIME_W-1:0]     req_trip_limit_ms,
   input  logic [fdlm_pkg::TIME_W-1:0]     req_recovery_limit_ms,
   input  logic [1:0]                      req_latch_mode,
   input  logic [31:0]                     req_slot_actions,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_is_active,
   output logic                            rsp_is_latched,
   output logic                            rsp_is_effective,
   output logic                            rsp_raw_seen,
   output logic [31:0]                     rsp_occurrences,
   output logic [fdlm_pkg::TIME_W-1:0]     rsp_first_stamp,
   output logic [fdlm_pkg::TIME_W-1:0]     rsp_change_stamp,
   output logic                            rsp_ever_active,
   output logic [31:0]                     rsp_combined_actions,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fdlm_pkg::COUNT_W-1:0]    csr_fault_count
);

   fdlm_pkg::req_type                    in_ff;
   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   fdlm_pkg::rsp_type                    rsp_ff;
   fdlm_pkg::rsp_type                    rsp_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [fdlm_pkg::COUNT_W-1:0]         count_ff;
   fdlm_pkg::slot_type                   slot_ff [fdlm_pkg::FAULT_SLOTS];
   fdlm_pkg::desc_type                   desc_ff [fdlm_pkg::FAULT_SLOTS];
   fdlm_pkg::slot_type                   slot_in;
   fdlm_pkg::desc_type                   desc_in;
   fdlm_pkg::req_type                    req_item;
   logic                                 accept;
   logic                                 advance;

   fdlm_pkg::slot_type                   cur;
   fdlm_pkg::desc_type                   dsc;
   logic                                 id_ok;
   logic [fdlm_pkg::TIME_W-1:0]          timer_sel;
   logic [fdlm_pkg::TIME_W:0]            timer_sum;
   logic [fdlm_pkg::TIME_W-1:0]          timer_sat;
   logic [31:0]                          occ_inc;
   logic                                 eff;
   logic [31:0]                          acts;
   logic [31:0]                          combined;
   fdlm_pkg::status_type                 status;

   assign req_item = '{
      operation:         req_operation,
      fault_id:          req_fault_id,
      fault_raw:         req_fault_raw,
      delta_ms:          req_delta_ms,
      now_ms:            req_now_ms,
      trip_limit_ms:     req_trip_limit_ms,
      recovery_limit_ms: req_recovery_limit_ms,
      latch_mode:        req_latch_mode,
      slot_actions:      req_slot_actions
   };

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // slot update for the item in the input register
   always_comb begin
      cur     = slot_ff[in_ff.fault_id];
      dsc     = desc_ff[in_ff.fault_id];
      slot_in = cur;
      desc_in = dsc;
      status  = fdlm_pkg::ST_OK;
      id_ok   = {1'b0, in_ff.fault_id} < count_ff;

      timer_sel = in_ff.fault_raw ? cur.trip_timer : cur.recovery_timer;
      timer_sum = {1'b0, timer_sel} + {1'b0, in_ff.delta_ms};
      timer_sat = timer_sum[fdlm_pkg::TIME_W] ? '1 : timer_sum[fdlm_pkg::TIME_W-1:0];
      occ_inc   = (cur.occurrences == '1) ? cur.occurrences : cur.occurrences + 32'd1;

      if (!id_ok) begin
         status = fdlm_pkg::ST_STATE;
      end else begin
         unique case (fdlm_pkg::op_type'(in_ff.operation))
            fdlm_pkg::OP_UPDATE: begin
               slot_in.raw_flag = in_ff.fault_raw;
               if (in_ff.fault_raw) begin
                  slot_in.recovery_timer = '0;
                  if (!cur.active_flag) begin
                     slot_in.trip_timer = timer_sat;
                     if (timer_sat >= dsc.trip_limit) begin
                        slot_in.active_flag  = 1'b1;
                        slot_in.change_time  = in_ff.now_ms;
                        slot_in.occurrences  = occ_inc;
                        slot_in.history_flag = 1'b1;
                        if (cur.occurrences == '0) begin
                           slot_in.first_seen = in_ff.now_ms;
                        end
                        if (dsc.latch_mode != fdlm_pkg::LATCH_NONE) begin
                           slot_in.latched_flag = 1'b1;
                        end
                     end
                  end
               end else begin
                  slot_in.trip_timer     = '0;
                  slot_in.recovery_timer = '0;
                  if (cur.active_flag) begin
                     slot_in.recovery_timer = timer_sat;
                     if (timer_sat >= dsc.recovery_limit) begin
                        slot_in.active_flag    = 1'b0;
                        slot_in.recovery_timer = '0;
                        slot_in.change_time    = in_ff.now_ms;
                        if (dsc.latch_mode == fdlm_pkg::LATCH_NONE) begin
                           slot_in.latched_flag = 1'b0;
                        end
                     end
                  end
               end
            end
            fdlm_pkg::OP_CLEAR: begin
               if (dsc.latch_mode != fdlm_pkg::LATCH_MANUAL || cur.raw_flag ||
                   cur.active_flag) begin
                  status = fdlm_pkg::ST_STATE;
               end else begin
                  slot_in.latched_flag = 1'b0;
                  slot_in.change_time  = in_ff.now_ms;
               end
            end
            fdlm_pkg::OP_WRITE: begin
               if (in_ff.latch_mode != fdlm_pkg::LATCH_NONE &&
                   in_ff.latch_mode != fdlm_pkg::LATCH_MANUAL &&
                   in_ff.latch_mode != fdlm_pkg::LATCH_POWER) begin
                  status = fdlm_pkg::ST_MISMATCH;
               end else begin
                  desc_in.trip_limit     = in_ff.trip_limit_ms;
                  desc_in.recovery_limit = in_ff.recovery_limit_ms;
                  desc_in.latch_mode     = in_ff.latch_mode;
                  desc_in.actions        = in_ff.slot_actions;
                  slot_in                = '0;
               end
            end
            default: begin
               status = fdlm_pkg::ST_STATE;
            end
         endcase
      end
   end

   // action OR over effective slots in use, with the addressed slot updated
   always_comb begin
      combined = '0;
      for (int s = 0; s < fdlm_pkg::FAULT_SLOTS; s++) begin
         if (fdlm_pkg::SLOT_W'(s) == in_ff.fault_id) begin
            eff  = slot_in.active_flag || slot_in.latched_flag;
            acts = desc_in.actions;
         end else begin
            eff  = slot_ff[s].active_flag || slot_ff[s].latched_flag;
            acts = desc_ff[s].actions;
         end
         if (eff && (fdlm_pkg::COUNT_W'(s) < count_ff)) begin
            combined = combined | acts;
         end
      end
   end

   always_comb begin
      rsp_in                  = '0;
      rsp_in.status           = status;
      rsp_in.combined_actions = combined;
      if (id_ok) begin
         rsp_in.is_active    = slot_in.active_flag;
         rsp_in.is_latched   = slot_in.latched_flag;
         rsp_in.is_effective = slot_in.active_flag || slot_in.latched_flag;
         rsp_in.raw_seen     = slot_in.raw_flag;
         rsp_in.occurrences  = slot_in.occurrences;
         rsp_in.first_stamp  = slot_in.first_seen;
         rsp_in.change_stamp = slot_in.change_time;
         rsp_in.ever_active  = slot_in.history_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= fdlm_pkg::COUNT_RESET;
         for (int s = 0; s < fdlm_pkg::FAULT_SLOTS; s++) begin
            slot_ff[s] <= '0;
            desc_ff[s] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_fault_count;
         end
         if (advance) begin
            slot_ff[in_ff.fault_id] <= slot_in;
            desc_ff[in_ff.fault_id] <= desc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_is_active        = rsp_ff.is_active;
   assign rsp_is_latched       = rsp_ff.is_latched;
   assign rsp_is_effective     = rsp_ff.is_effective;
   assign rsp_raw_seen         = rsp_ff.raw_seen;
   assign rsp_occurrences      = rsp_ff.occurrences;
   assign rsp_first_stamp      = rsp_ff.first_stamp;
   assign rsp_change_stamp     = rsp_ff.change_stamp;
   assign rsp_ever_active      = rsp_ff.ever_active;
   assign rsp_combined_actions = rsp_ff.combined_actions;

endmodule
